/* src/twl_pkg.sv */
// Shared types, widths, constants and the monthly sun table for the twilight lamp core.
// No dependencies; every other file in src imports this package.
package twl_pkg;

   localparam int TIME_W     = 17;   // second of day, also config register width
   localparam int BOUND_W    = 18;   // window bounds after adding a trail
   localparam int MIN_W      = 11;   // minute of day from the sun table
   localparam int NUM_W      = 25;   // 100 * offset, dividend of the ramp
   localparam int QUOT_W     = 8;    // ramp quotient before saturation
   localparam int INT_W      = 7;    // intensity width
   localparam int CSR_IDX_W  = 2;

   localparam int NUM_STAGES = 10;
   localparam int STG_WIN    = 2;
   localparam int STG_RAMP   = 3;
   localparam int RAMP_STAGES = 2;
   localparam int STG_DIV    = 5;
   localparam int DIV_STAGES = 4;
   localparam int STG_OUT    = 9;
   localparam int DIV_STEP   = QUOT_W / DIV_STAGES;

   localparam logic [TIME_W-1:0] SEC_PER_HOUR = TIME_W'(3600);
   localparam logic [TIME_W-1:0] SEC_PER_MIN  = TIME_W'(60);
   localparam logic [INT_W-1:0]  FULL_SCALE   = INT_W'(100);

   localparam logic [3:0] MONTH_MARCH   = 4'd3;
   localparam logic [3:0] MONTH_OCTOBER = 4'd10;
   localparam logic [2:0] WDAY_SUNDAY   = 3'd7;
   localparam logic [4:0] LAST_WEEK_DAY = 5'd24;  // day + 7 > 31
   localparam logic [5:0] MONTH_DAYS    = 6'd31;

   localparam logic [CSR_IDX_W-1:0] CSR_EVENING_LEAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENING_STOP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MORNING_START = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MORNING_TRAIL = 2'd3;

   localparam logic [TIME_W-1:0] RST_EVENING_LEAD  = TIME_W'(3600);
   localparam logic [TIME_W-1:0] RST_EVENING_STOP  = TIME_W'(82800);
   localparam logic [TIME_W-1:0] RST_MORNING_START = TIME_W'(18000);
   localparam logic [TIME_W-1:0] RST_MORNING_TRAIL = TIME_W'(1800);

   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [BOUND_W-1:0] width;
      logic               active;
   } ramp_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic              active;
   } div_out_type;

   // UTC sunset, minute of day; unused month codes read zero
   function automatic logic [MIN_W-1:0] sunset_min(input logic [3:0] month);
      logic [MIN_W-1:0] m;
      case (month)
         4'd1:    m = MIN_W'(15 * 60 + 29);
         4'd2:    m = MIN_W'(16 * 60 + 21);
         4'd3:    m = MIN_W'(17 * 60 + 9);
         4'd4:    m = MIN_W'(18 * 60 + 7);
         4'd5:    m = MIN_W'(18 * 60 + 43);
         4'd6:    m = MIN_W'(19 * 60 + 14);
         4'd7:    m = MIN_W'(19 * 60 + 5);
         4'd8:    m = MIN_W'(18 * 60 + 18);
         4'd9:    m = MIN_W'(17 * 60 + 12);
         4'd10:   m = MIN_W'(16 * 60 + 6);
         4'd11:   m = MIN_W'(15 * 60 + 16);
         4'd12:   m = MIN_W'(15 * 60 + 0);
         default: m = '0;
      endcase
      return m;
   endfunction

   // UTC sunrise, minute of day
   function automatic logic [MIN_W-1:0] sunrise_min(input logic [3:0] month);
      logic [MIN_W-1:0] m;
      case (month)
         4'd1:    m = MIN_W'(5 * 60 + 54);
         4'd2:    m = MIN_W'(6 * 60 + 12);
         4'd3:    m = MIN_W'(5 * 60 + 13);
         4'd4:    m = MIN_W'(4 * 60 + 6);
         4'd5:    m = MIN_W'(3 * 60 + 14);
         4'd6:    m = MIN_W'(2 * 60 + 52);
         4'd7:    m = MIN_W'(3 * 60 + 11);
         4'd8:    m = MIN_W'(3 * 60 + 53);
         4'd9:    m = MIN_W'(4 * 60 + 40);
         4'd10:   m = MIN_W'(5 * 60 + 26);
         4'd11:   m = MIN_W'(6 * 60 + 17);
         4'd12:   m = MIN_W'(6 * 60 + 55);
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

/* src/twl_front.sv */
// Front stages: time of day, summer-time decision, sun table lookup, local sun times.
// Depends on twl_pkg.
module twl_front import twl_pkg::*; (
   input  logic              clock,
   input  logic [1:0]        en,
   input  logic [3:0]        month,
   input  logic [4:0]        day_of_month,
   input  logic [2:0]        week_day,
   input  logic [4:0]        hour,
   input  logic [5:0]        minute,
   input  logic [5:0]        second,
   output logic [TIME_W-1:0] tod,
   output logic [TIME_W-1:0] sunset_s,
   output logic [TIME_W-1:0] sunrise_s
);

   logic [TIME_W-1:0] tod_in, tod1_ff, tod2_ff;
   logic              summer_in, summer_ff;
   logic [MIN_W-1:0]  set_min_in, set_min_ff, rise_min_in, rise_min_ff;
   logic [TIME_W-1:0] shift;
   logic [TIME_W-1:0] sunset_in, sunset_ff, sunrise_in, sunrise_ff;
   logic [5:0]        cross_sum;
   logic              crosses, late;

   always_comb begin
      tod_in = TIME_W'(hour) * SEC_PER_HOUR + TIME_W'(minute) * SEC_PER_MIN
               + TIME_W'(second);

      // Last Sunday of the month already passed, or falls today when Sunday
      cross_sum = 6'(3'(WDAY_SUNDAY - week_day)) + 6'(day_of_month);
      crosses   = cross_sum > MONTH_DAYS;
      late      = day_of_month > LAST_WEEK_DAY;

      if (month < MONTH_MARCH || month > MONTH_OCTOBER) begin
         summer_in = 1'b0;
      end else if (month > MONTH_MARCH && month < MONTH_OCTOBER) begin
         summer_in = 1'b1;
      end else if (month == MONTH_MARCH) begin
         summer_in = crosses || (week_day == WDAY_SUNDAY && late);
      end else begin
         summer_in = !crosses && (week_day != WDAY_SUNDAY || !late);
      end

      set_min_in  = sunset_min(month);
      rise_min_in = sunrise_min(month);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tod1_ff     <= tod_in;
         summer_ff   <= summer_in;
         set_min_ff  <= set_min_in;
         rise_min_ff <= rise_min_in;
      end
   end

   // UTC+1, one more hour in summer
   always_comb begin
      shift      = summer_ff ? TIME_W'(2 * 3600) : SEC_PER_HOUR;
      sunset_in  = TIME_W'(set_min_ff) * SEC_PER_MIN + shift;
      sunrise_in = TIME_W'(rise_min_ff) * SEC_PER_MIN + shift;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tod2_ff    <= tod1_ff;
         sunset_ff  <= sunset_in;
         sunrise_ff <= sunrise_in;
      end
   end

   assign tod       = tod2_ff;
   assign sunset_s  = sunset_ff;
   assign sunrise_s = sunrise_ff;

endmodule

/* src/twl_ramp.sv */
// Ramp setup for one window: peak, half width, offset and scaled dividend.
// Depends on twl_pkg.
module twl_ramp import twl_pkg::*; (
   input  logic                   clock,
   input  logic [RAMP_STAGES-1:0] en,
   input  logic [TIME_W-1:0]      tod,
   input  logic [BOUND_W-1:0]     win_start,
   input  logic [BOUND_W-1:0]     win_end,
   input  logic                   win_ok,
   output ramp_type               ramp
);

   logic [BOUND_W-1:0] t_ext, mid, width_in, width_ff, x_in, x_ff;
   logic               rising, falling, active_in, active_ff;
   ramp_type           ramp_in, ramp_ff;

   always_comb begin
      t_ext     = BOUND_W'(tod);
      mid       = (win_end >> 1) + (win_start >> 1);
      width_in  = mid - win_start;
      rising    = t_ext > win_start && t_ext < mid;
      falling   = t_ext > mid && t_ext < win_end;
      x_in      = rising ? t_ext - win_start : win_end - t_ext;
      active_in = win_ok && mid > win_start && (rising || falling);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         width_ff  <= width_in;
         x_ff      <= x_in;
         active_ff <= active_in;
      end
   end

   // Scale by 100; zero the dividend outside the window
   always_comb begin
      ramp_in.num    = active_ff ? NUM_W'(x_ff) * NUM_W'(FULL_SCALE) : '0;
      ramp_in.width  = width_ff;
      ramp_in.active = active_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ramp_ff <= ramp_in;
      end
   end

   assign ramp = ramp_ff;

endmodule

/* src/twl_div.sv */
// Pipelined restoring divider for the ramp, two quotient bits per stage.
// Depends on twl_pkg; the quotient is known to stay below 2**QUOT_W.
module twl_div import twl_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  ramp_type              ramp,
   output div_out_type           result
);

   logic [NUM_W-1:0]   rem_ff   [DIV_STAGES];
   logic [QUOT_W-1:0]  quot_ff  [DIV_STAGES];
   logic [BOUND_W-1:0] width_ff [DIV_STAGES];
   logic               act_ff   [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [NUM_W-1:0]   rem_src, rem_in, dvs;
      logic [QUOT_W-1:0]  quot_src, quot_in;
      logic [BOUND_W-1:0] width_src;
      logic               act_src;

      if (j == 0) begin : g_first
         assign rem_src   = ramp.num;
         assign quot_src  = '0;
         assign width_src = ramp.width;
         assign act_src   = ramp.active;
      end else begin : g_next
         assign rem_src   = rem_ff[j-1];
         assign quot_src  = quot_ff[j-1];
         assign width_src = width_ff[j-1];
         assign act_src   = act_ff[j-1];
      end

      always_comb begin
         rem_in  = rem_src;
         quot_in = quot_src;
         dvs     = '0;
         for (int b = 0; b < DIV_STEP; b++) begin
            dvs = NUM_W'(width_src) << (QUOT_W - 1 - DIV_STEP * j - b);
            if (rem_in >= dvs) begin
               rem_in  = rem_in - dvs;
               quot_in = {quot_in[QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_in[QUOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j]   <= rem_in;
            quot_ff[j]  <= quot_in;
            width_ff[j] <= width_src;
            act_ff[j]   <= act_src;
         end
      end
   end

   assign result.quot   = quot_ff[DIV_STAGES-1];
   assign result.active = act_ff[DIV_STAGES-1];

endmodule

/* src/twilight_lamp_intensity_core.sv */
// Top level of the twilight lamp intensity core: config registers, pipeline control,
// window bounds and final selection. Depends on twl_pkg, twl_front, twl_ramp, twl_div.
//
// Usage:
//   Request channel (req_*): one item is a date (month, day, weekday) and a local
//   standard time of day. Result channel (rsp_*): one item per request, the lamp
//   intensity 0..100, in request order.
//   Config channel (csr_*): always ready; index 0 evening lead, 1 evening stop,
//   2 morning start, 3 morning trail, 17 bits each. Write only while idle.
//   Pipeline: ten register stages; the edge that accepts an item loads the first
//   stage, and rsp_valid rises when it reaches the last. Throughput: one item per
//   cycle while rsp_ready holds, set by the pipeline itself; the two ramp divisions
//   run in four divider stages of two quotient bits each, one divider per window.
//   Reset (synchronous, active high) empties the pipeline and loads the default
//   windows: lead 3600 s, stop 82800 s, start 18000 s, trail 1800 s.
//   When the receiver stalls, the result holds in the output register and each
//   stage keeps accepting while a bubble lies ahead of it, so req_ready drops
//   only once every stage holds an item.
module twilight_lamp_intensity_core import twl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_month,
   input  logic [4:0]           req_day_of_month,
   input  logic [2:0]           req_week_day,
   input  logic [4:0]           req_hour,
   input  logic [5:0]           req_minute,
   input  logic [5:0]           req_second,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [INT_W-1:0]     rsp_intensity,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   // Config registers
   logic [TIME_W-1:0] eve_lead_ff, eve_stop_ff, mor_start_ff, mor_trail_ff;

   // Pipeline control: one valid bit per stage, enable ripples back from output
   logic [NUM_STAGES-1:0] valid_ff, valid_in, en;

   // Stage datapath
   logic [TIME_W-1:0]  tod2, sunset_s, sunrise_s;
   logic [TIME_W-1:0]  tod3_in, tod3_ff, eve_start_in, eve_start_ff;
   logic               eve_ok_in, eve_ok_ff, mor_ok_in, mor_ok_ff;
   logic [BOUND_W-1:0] mor_end_in, mor_end_ff;
   ramp_type           eve_ramp, mor_ramp;
   div_out_type        eve_div, mor_div;
   logic [INT_W-1:0]   eve_val, mor_val, out_in, out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eve_lead_ff  <= RST_EVENING_LEAD;
         eve_stop_ff  <= RST_EVENING_STOP;
         mor_start_ff <= RST_MORNING_START;
         mor_trail_ff <= RST_MORNING_TRAIL;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EVENING_LEAD:  eve_lead_ff  <= csr_wdata;
            CSR_EVENING_STOP:  eve_stop_ff  <= csr_wdata;
            CSR_MORNING_START: mor_start_ff <= csr_wdata;
            CSR_MORNING_TRAIL: mor_trail_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or the stage after it moves
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];

   twl_front u_front (
      .clock        (clock),
      .en           (en[STG_WIN-1:0]),
      .month        (req_month),
      .day_of_month (req_day_of_month),
      .week_day     (req_week_day),
      .hour         (req_hour),
      .minute       (req_minute),
      .second       (req_second),
      .tod          (tod2),
      .sunset_s     (sunset_s),
      .sunrise_s    (sunrise_s)
   );

   // Window bounds: evening opens lead seconds before sunset and drops if that
   // underflows or stop is not after it; morning closes trail seconds after sunrise.
   always_comb begin
      tod3_in      = tod2;
      eve_start_in = sunset_s - eve_lead_ff;
      eve_ok_in    = eve_lead_ff <= sunset_s && eve_stop_ff > eve_start_in;
      mor_end_in   = BOUND_W'(sunrise_s) + BOUND_W'(mor_trail_ff);
      mor_ok_in    = mor_end_in > BOUND_W'(mor_start_ff);
   end

   always_ff @(posedge clock) begin
      if (en[STG_WIN]) begin
         tod3_ff      <= tod3_in;
         eve_start_ff <= eve_start_in;
         eve_ok_ff    <= eve_ok_in;
         mor_end_ff   <= mor_end_in;
         mor_ok_ff    <= mor_ok_in;
      end
   end

   twl_ramp u_eve_ramp (
      .clock     (clock),
      .en        (en[STG_DIV-1:STG_RAMP]),
      .tod       (tod3_ff),
      .win_start (BOUND_W'(eve_start_ff)),
      .win_end   (BOUND_W'(eve_stop_ff)),
      .win_ok    (eve_ok_ff),
      .ramp      (eve_ramp)
   );

   twl_ramp u_mor_ramp (
      .clock     (clock),
      .en        (en[STG_DIV-1:STG_RAMP]),
      .tod       (tod3_ff),
      .win_start (BOUND_W'(mor_start_ff)),
      .win_end   (mor_end_ff),
      .win_ok    (mor_ok_ff),
      .ramp      (mor_ramp)
   );

   twl_div u_eve_div (
      .clock  (clock),
      .en     (en[STG_OUT-1:STG_DIV]),
      .ramp   (eve_ramp),
      .result (eve_div)
   );

   twl_div u_mor_div (
      .clock  (clock),
      .en     (en[STG_OUT-1:STG_DIV]),
      .ramp   (mor_ramp),
      .result (mor_div)
   );

   // Saturate the falling half at full scale; fall back to morning when the
   // evening ramp gives nothing.
   always_comb begin
      eve_val = '0;
      mor_val = '0;
      if (eve_div.active) begin
         eve_val = (eve_div.quot > QUOT_W'(FULL_SCALE)) ? FULL_SCALE
                                                         : INT_W'(eve_div.quot);
      end
      if (mor_div.active) begin
         mor_val = (mor_div.quot > QUOT_W'(FULL_SCALE)) ? FULL_SCALE
                                                         : INT_W'(mor_div.quot);
      end
      out_in = (eve_val != '0) ? eve_val : mor_val;
   end

   always_ff @(posedge clock) begin
      if (en[STG_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid     = valid_ff[STG_OUT];
   assign rsp_intensity = out_ff;

endmodule
